>>> hdl/mzs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzs_pkg
// shared types and constants of the modified z-score outlier core
// ----------------------------------------------------------------------------
package mzs_pkg;

  localparam int unsigned KEY_W  = 19;
  localparam int unsigned MED_W  = 18;
  localparam int unsigned MAD_W  = 19;
  localparam int unsigned PROD_W = 34;
  localparam int unsigned DIV_W  = 44;
  localparam int unsigned Q_W    = 17;

  localparam logic [1:0] STS_FINITE  = 2'd0;
  localparam logic [1:0] STS_NAN     = 2'd1;
  localparam logic [1:0] STS_POS_INF = 2'd2;
  localparam logic [1:0] STS_NEG_INF = 2'd3;

  localparam logic [15:0] SCALE_RESET = 16'd44204;
  localparam logic        REG_Z_SCALE = 1'b0;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               finite;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic [1:0]         status;
    logic               last_out;
  } out_t;

  typedef struct packed {
    logic load;
    logic a_cap;
    logic b_cmp;
    logic chk;
    logic fin;
    logic rd_j;
    logic o_cap;
    logic o_mul;
    logic o_prep;
    logic o_div;
    logic o_emit;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic fin_nz;
    logic rd_finite;
    logic i_last;
    logic j_last;
    logic pass1;
    logic div_done;
  } sts_t;

  // sort key: raw sample in the first pass, absolute doubled deviation in the second
  function automatic logic signed [KEY_W-1:0] sort_key(
    input logic signed [15:0]      s,
    input logic                    pass1,
    input logic signed [MED_W-1:0] med
  );
    logic signed [KEY_W-1:0] d;
    d = {{(KEY_W-17){s[15]}}, s, 1'b0} - {{(KEY_W-MED_W){med[MED_W-1]}}, med};
    if (!pass1) begin
      sort_key = {{(KEY_W-16){s[15]}}, s};
    end else begin
      sort_key = d[KEY_W-1] ? -d : d;
    end
  endfunction

endpackage

>>> hdl/mzs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mzs_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mzs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzs_ctrl
// sequencer for load, two rank-selection passes and score output
// ----------------------------------------------------------------------------
module mzs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mzs_pkg::sts_t sts_i,
  output mzs_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import mzs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_ADDR = 4'd1;
  localparam logic [3:0] S_A_DATA = 4'd2;
  localparam logic [3:0] S_B_ADDR = 4'd3;
  localparam logic [3:0] S_B_DATA = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_O_ADDR = 4'd7;
  localparam logic [3:0] S_O_DATA = 4'd8;
  localparam logic [3:0] S_O_MUL  = 4'd9;
  localparam logic [3:0] S_O_PREP = 4'd10;
  localparam logic [3:0] S_O_DIV  = 4'd11;
  localparam logic [3:0] S_O_EMIT = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
        if (start_i && sts_i.frame_end) begin
          state_d = sts_i.fin_nz ? S_A_ADDR : S_O_ADDR;
        end
      end
      S_A_ADDR: state_d = S_A_DATA;
      S_A_DATA: begin
        cmd_o.a_cap = 1'b1;
        if (sts_i.rd_finite) begin
          state_d = S_B_ADDR;
        end else begin
          state_d = sts_i.i_last ? S_FIN : S_A_ADDR;
        end
      end
      S_B_ADDR: begin
        cmd_o.rd_j = 1'b1;
        state_d    = S_B_DATA;
      end
      S_B_DATA: begin
        cmd_o.b_cmp = 1'b1;
        state_d     = sts_i.j_last ? S_CHK : S_B_ADDR;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.i_last ? S_FIN : S_A_ADDR;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = sts_i.pass1 ? S_O_ADDR : S_A_ADDR;
      end
      S_O_ADDR: state_d = S_O_DATA;
      S_O_DATA: begin
        cmd_o.o_cap = 1'b1;
        state_d     = S_O_MUL;
      end
      S_O_MUL: begin
        cmd_o.o_mul = 1'b1;
        state_d     = S_O_PREP;
      end
      S_O_PREP: begin
        cmd_o.o_prep = 1'b1;
        state_d      = S_O_DIV;
      end
      S_O_DIV: begin
        cmd_o.o_div = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_O_EMIT;
        end
      end
      S_O_EMIT: begin
        cmd_o.o_emit = 1'b1;
        state_d      = sts_i.i_last ? S_IDLE : S_O_ADDR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hdl/mzs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzs_dp
// frame store, rank selection counters, scaling multiplier and divider
// ----------------------------------------------------------------------------
module mzs_dp #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mzs_pkg::cmd_t cmd_i,
  input  mzs_pkg::in_t  in_i,
  input  logic [15:0]   z_scale_i,
  output mzs_pkg::sts_t sts_o,
  output mzs_pkg::out_t res_o
);
  import mzs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  logic [CW-1:0] cnt_q, n_q, m_q, i_q, j_q, lt_q, eq_q;
  logic          any_q, pass_q;
  logic signed [KEY_W-1:0] key_i_q, lo_q, hi_q;
  logic signed [MED_W-1:0] med_q;
  logic [MAD_W-1:0]        mad_q;
  logic signed [15:0]      s_q;
  logic                    f_q;
  logic [PROD_W-1:0]       prod_q;
  logic [DIV_W-1:0]        rem_q, dsh_q;
  logic [Q_W-1:0]          quot_q;
  logic                    ovf_q;
  logic [4:0]              dcnt_q;

  logic [16:0]   rdata;
  logic [AW-1:0] raddr;
  logic signed [KEY_W-1:0] rkey;
  logic [CW-1:0] p_hi, p_lo;
  logic [CW:0]   lt_eq;
  logic signed [KEY_W:0]   key_sum;
  logic signed [KEY_W-1:0] dev;
  logic [MED_W-1:0]        mag;
  logic [DIV_W-1:0]        num, mad_x;
  logic [15:0]             qsat;

  assign raddr = cmd_i.rd_j ? j_q[AW-1:0] : i_q[AW-1:0];

  mzs_ram #(
    .WIDTH (17),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({in_i.finite, in_i.sample}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rkey    = sort_key(rdata[15:0], pass_q, med_q);
  assign p_hi    = m_q >> 1;
  assign p_lo    = m_q[0] ? p_hi : p_hi - CW'(1);
  assign lt_eq   = {1'b0, lt_q} + {1'b0, eq_q};
  assign key_sum = {lo_q[KEY_W-1], lo_q} + {hi_q[KEY_W-1], hi_q};

  assign dev   = {{(KEY_W-17){s_q[15]}}, s_q, 1'b0}
               - {{(KEY_W-MED_W){med_q[MED_W-1]}}, med_q};
  assign mag   = dev[KEY_W-1] ? MED_W'(-dev) : MED_W'(dev);
  assign mad_x = DIV_W'(mad_q);
  assign num   = DIV_W'({prod_q, 1'b0}) + (mad_x << 7);

  assign sts_o.frame_end = in_i.last_in || (cnt_q + CW'(1) == MAX_CNT);
  assign sts_o.fin_nz    = (m_q != '0) || in_i.finite;
  assign sts_o.rd_finite = rdata[16];
  assign sts_o.i_last    = (i_q + CW'(1) == n_q);
  assign sts_o.j_last    = (j_q + CW'(1) == n_q);
  assign sts_o.pass1     = pass_q;
  assign sts_o.div_done  = (dcnt_q == 5'(Q_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      n_q    <= '0;
      m_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      any_q  <= 1'b0;
      pass_q <= 1'b0;
      med_q  <= '0;
      mad_q  <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (sts_o.frame_end) begin
          n_q    <= cnt_q + CW'(1);
          cnt_q  <= '0;
          any_q  <= sts_o.fin_nz;
          i_q    <= '0;
          pass_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
        m_q <= m_q + CW'(in_i.finite);
      end
      if (cmd_i.a_cap) begin
        if (rdata[16]) begin
          j_q <= '0;
        end else begin
          i_q <= i_q + CW'(1);
        end
      end
      if (cmd_i.b_cmp) begin
        j_q <= j_q + CW'(1);
      end
      if (cmd_i.chk) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.fin) begin
        i_q <= '0;
        if (!pass_q) begin
          med_q  <= MED_W'(key_sum);
          pass_q <= 1'b1;
        end else begin
          mad_q <= MAD_W'(key_sum);
        end
      end
      if (cmd_i.o_prep) begin
        dcnt_q <= '0;
      end
      if (cmd_i.o_div) begin
        dcnt_q <= dcnt_q + 5'd1;
      end
      if (cmd_i.o_emit) begin
        i_q <= i_q + CW'(1);
        if (sts_o.i_last) begin
          m_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_cap && rdata[16]) begin
      key_i_q <= rkey;
      lt_q    <= '0;
      eq_q    <= '0;
    end
    if (cmd_i.b_cmp && rdata[16]) begin
      if (rkey < key_i_q) begin
        lt_q <= lt_q + CW'(1);
      end else if (rkey == key_i_q) begin
        eq_q <= eq_q + CW'(1);
      end
    end
    if (cmd_i.chk) begin
      if ((lt_q <= p_lo) && ({1'b0, p_lo} < lt_eq)) begin
        lo_q <= key_i_q;
      end
      if ((lt_q <= p_hi) && ({1'b0, p_hi} < lt_eq)) begin
        hi_q <= key_i_q;
      end
    end
    if (cmd_i.o_cap) begin
      s_q <= rdata[15:0];
      f_q <= rdata[16];
    end
    if (cmd_i.o_mul) begin
      prod_q <= PROD_W'(mag) * PROD_W'(z_scale_i);
    end
    if (cmd_i.o_prep) begin
      rem_q  <= num;
      dsh_q  <= mad_x << 24;
      ovf_q  <= (num >= (mad_x << 25));
      quot_q <= '0;
    end
    if (cmd_i.o_div) begin
      if (rem_q >= dsh_q) begin
        rem_q  <= rem_q - dsh_q;
        quot_q <= {quot_q[Q_W-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[Q_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  always_comb begin
    qsat = 16'h0000;
    res_o.last_out = sts_o.i_last;
    if (!any_q || !f_q) begin
      res_o.score  = 16'sd0;
      res_o.status = STS_NAN;
    end else if (mad_q == '0) begin
      if (dev == '0) begin
        res_o.score  = 16'sd0;
        res_o.status = STS_FINITE;
      end else if (!dev[KEY_W-1]) begin
        res_o.score  = 16'sh7FFF;
        res_o.status = STS_POS_INF;
      end else begin
        res_o.score  = 16'sh8000;
        res_o.status = STS_NEG_INF;
      end
    end else begin
      res_o.status = STS_FINITE;
      if (!dev[KEY_W-1]) begin
        qsat = (ovf_q || quot_q > 17'd32767) ? 16'h7FFF : quot_q[15:0];
        res_o.score = qsat;
      end else begin
        qsat = (ovf_q || quot_q >= 17'd32768) ? 16'h8000 : quot_q[15:0];
        res_o.score = -qsat;
      end
    end
  end

endmodule

>>> hdl/modified_z_score_outliers_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modified_z_score_outliers_core
// median / median absolute deviation outlier scoring of one sample frame
// ----------------------------------------------------------------------------
// loading accepts one sample per cycle while busy is low
// after the final sample, two rank-selection passes run over the n samples
// through the single store read port, then each score goes through a
// 17-step serial divider; the receiver cannot stall, results are strobes
// reset clears control state and sets z_scale to 0.6745; the store needs none
module modified_z_score_outliers_core #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mzs_pkg::in_t  in_i,
  output logic          res_valid_o,
  output mzs_pkg::out_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import mzs_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        busy_w;
  logic [15:0] z_scale_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_Z_SCALE) ? {16'h0000, z_scale_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_scale_q <= SCALE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_Z_SCALE)) begin
      z_scale_q <= pwdata[15:0];
    end
  end

  mzs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_w)
  );

  mzs_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_i      (in_i),
    .z_scale_i (z_scale_q),
    .sts_o     (sts),
    .res_o     (res_o)
  );

  assign busy        = busy_w;
  assign res_valid_o = cmd.o_emit;

endmodule
